[sv/adamw_pkg.sv]
// Shared types, register codes and fixed-point constants for the AdamW update pipeline.
// Used by every module of the block; depends on nothing else.
package adamw_pkg;

  localparam int FracBits         = 24;
  localparam int DefaultDataWidth = 32;

  localparam logic [24:0] OneQ      = 25'h100_0000;
  localparam logic [40:0] UpdLimit  = 41'h100_0000_0000;
  localparam logic signed [63:0] HalfS = 64'sd8388608;
  localparam logic [63:0] HalfU     = 64'd8388608;

  localparam logic [24:0] BetaOneRst   = 25'd15099494;
  localparam logic [24:0] BetaTwoRst   = 25'd16760439;
  localparam logic [30:0] StepRateRst  = 31'd16777;
  localparam logic [24:0] EpsilonRst   = 25'd1;
  localparam logic [24:0] DecayStepRst = 25'd0;

  typedef enum logic [2:0] {
    CFG_BETA_ONE   = 3'd0,
    CFG_BETA_TWO   = 3'd1,
    CFG_STEP_RATE  = 3'd2,
    CFG_EPSILON    = 3'd3,
    CFG_DECAY_STEP = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [24:0] b1;
    logic [24:0] b2;
    logic [24:0] wd;
    logic [24:0] eps;
    logic [30:0] rate;
  } coef_t;

  typedef struct packed {
    logic signed [31:0] p;
    logic signed [32:0] dec;
    logic signed [31:0] m_new;
    logic [30:0]        v_new;
    logic [62:0]        prod;
    logic               last;
  } side_t;

  function automatic logic [24:0] clamp_one(logic [24:0] c);
    return (c > OneQ) ? OneQ : c;
  endfunction

endpackage

[sv/adamw_moments.sv]
// Five-stage front end: moment products, rounding, variance update and the rate product.
// Depends on adamw_pkg.
module adamw_moments import adamw_pkg::*; #(
  parameter int DATA_WIDTH = DefaultDataWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] param_i,
  input  logic [31:0] grad_i,
  input  logic [31:0] moment_in_i,
  input  logic [30:0] variance_in_i,
  input  logic        last_in_i,
  input  coef_t       coef_i,
  output logic        valid_o,
  output side_t       side_o
);

  localparam int WordW = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
  localparam int ExtSh = 32 - WordW;
  localparam logic signed [63:0] SatHi = (64'sd1 <<< (WordW - 1)) - 64'sd1;
  localparam logic signed [63:0] SatLo = -SatHi - 64'sd1;
  localparam logic [30:0] VMax = 31'(SatHi);

  logic signed [31:0] p_s, g_s, m_s;
  logic [31:0] gmag;
  logic [30:0] v_c;
  logic [24:0] omb1, omb2;

  assign p_s  = $signed(param_i << ExtSh) >>> ExtSh;
  assign g_s  = $signed(grad_i << ExtSh) >>> ExtSh;
  assign m_s  = $signed(moment_in_i << ExtSh) >>> ExtSh;
  assign gmag = g_s[31] ? 32'(-g_s) : 32'(g_s);
  assign v_c  = (variance_in_i > VMax) ? VMax : variance_in_i;
  assign omb1 = OneQ - coef_i.b1;
  assign omb2 = OneQ - coef_i.b2;

  logic [4:0] vld_q;

  logic signed [57:0] s1_b1m_q, s1_omg_q, s1_wdp_q;
  logic [63:0]        s1_gsq_q;
  logic signed [31:0] s1_p_q;
  logic [30:0]        s1_v_q;
  logic               s1_last_q;

  logic signed [31:0] s2_m_q, s3_m_q, s4_m_q;
  logic [38:0]        s2_gsq_q;
  logic signed [32:0] s2_dec_q, s3_dec_q, s4_dec_q;
  logic signed [31:0] s2_p_q, s3_p_q, s4_p_q;
  logic [30:0]        s2_v_q, s4_v_q;
  logic               s2_last_q, s3_last_q, s4_last_q;
  logic [55:0]        s3_bv_q;
  logic [62:0]        s3_ovg_q;
  logic [31:0]        s4_mmag_q;
  side_t              s5_q;

  logic signed [63:0] macc, mr, decr;
  logic signed [31:0] m_new;
  logic [63:0]        gsq_r, vacc, vr;
  logic [30:0]        v_new;

  assign macc  = 64'(s1_b1m_q) + 64'(s1_omg_q) + HalfS;
  assign mr    = macc >>> FracBits;
  assign m_new = (mr > SatHi) ? 32'(SatHi) : ((mr < SatLo) ? 32'(SatLo) : 32'(mr));
  assign gsq_r = (s1_gsq_q + HalfU) >> FracBits;
  assign decr  = (64'(s1_wdp_q) + HalfS) >>> FracBits;
  assign vacc  = 64'(s3_bv_q) + 64'(s3_ovg_q) + HalfU;
  assign vr    = vacc >> FracBits;
  assign v_new = (vr > 64'(VMax)) ? VMax : vr[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_b1m_q  <= $signed({1'b0, coef_i.b1}) * m_s;
      s1_omg_q  <= $signed({1'b0, omb1}) * g_s;
      s1_wdp_q  <= $signed({1'b0, coef_i.wd}) * p_s;
      s1_gsq_q  <= gmag * gmag;
      s1_p_q    <= p_s;
      s1_v_q    <= v_c;
      s1_last_q <= last_in_i;

      s2_m_q    <= m_new;
      s2_gsq_q  <= gsq_r[38:0];
      s2_dec_q  <= 33'(decr);
      s2_p_q    <= s1_p_q;
      s2_v_q    <= s1_v_q;
      s2_last_q <= s1_last_q;

      s3_bv_q   <= coef_i.b2 * s2_v_q;
      s3_ovg_q  <= 63'(omb2 * s2_gsq_q);
      s3_m_q    <= s2_m_q;
      s3_dec_q  <= s2_dec_q;
      s3_p_q    <= s2_p_q;
      s3_last_q <= s2_last_q;

      s4_v_q    <= v_new;
      s4_mmag_q <= s3_m_q[31] ? 32'(-s3_m_q) : 32'(s3_m_q);
      s4_m_q    <= s3_m_q;
      s4_dec_q  <= s3_dec_q;
      s4_p_q    <= s3_p_q;
      s4_last_q <= s3_last_q;

      s5_q.prod  <= coef_i.rate * s4_mmag_q;
      s5_q.p     <= s4_p_q;
      s5_q.dec   <= s4_dec_q;
      s5_q.m_new <= s4_m_q;
      s5_q.v_new <= s4_v_q;
      s5_q.last  <= s4_last_q;
    end
  end

  assign valid_o = vld_q[4];
  assign side_o  = s5_q;

endmodule

[sv/adamw_sqrt.sv]
// Pipelined digit-by-digit square root of the new variance, one result bit per stage.
// Depends on adamw_pkg.
module adamw_sqrt import adamw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  side_t       side_i,
  output logic        valid_o,
  output side_t       side_o,
  output logic [27:0] root_o
);

  localparam int Steps = 28;

  logic        vld  [Steps+1];
  logic [27:0] root [Steps+1];
  logic [29:0] rem  [Steps+1];
  logic [55:0] xv   [Steps+1];
  side_t       sd   [Steps+1];

  assign vld[0]  = valid_i;
  assign root[0] = '0;
  assign rem[0]  = '0;
  assign xv[0]   = {1'b0, side_i.v_new, 24'd0};
  assign sd[0]   = side_i;

  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam int Dig = Steps - 1 - j;
    logic [31:0] remsh, trial;
    logic        ge;

    assign remsh = {rem[j], xv[j][2*Dig+1 -: 2]};
    assign trial = {2'b00, root[j], 2'b01};
    assign ge    = remsh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[j+1] <= 1'b0;
      end else if (en_i) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[j+1]  <= ge ? 30'(remsh - trial) : 30'(remsh);
        root[j+1] <= {root[j][26:0], ge};
        xv[j+1]   <= xv[j];
        sd[j+1]   <= sd[j];
      end
    end
  end

  assign valid_o = vld[Steps];
  assign side_o  = sd[Steps];
  assign root_o  = root[Steps];

endmodule

[sv/adamw_div.sv]
// Pipelined restoring divider for the rounded step quotient, one quotient bit per stage.
// Depends on adamw_pkg.
module adamw_div import adamw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  side_t       side_i,
  input  logic [27:0] root_i,
  input  logic [24:0] eps_i,
  output logic        valid_o,
  output side_t       side_o,
  output logic        ovf_o,
  output logic [40:0] quot_o
);

  localparam int QBits = 41;

  logic [28:0] den0;
  logic [62:0] num0;
  logic        ovf0;

  assign den0 = 29'(root_i) + 29'(eps_i);
  assign num0 = side_i.prod + 63'(den0 >> 1);
  assign ovf0 = 29'(num0[62:QBits]) >= den0;

  logic        vld  [QBits+1];
  logic [28:0] den  [QBits+1];
  logic [28:0] rem  [QBits+1];
  logic [40:0] quo  [QBits+1];
  logic [40:0] nlo  [QBits+1];
  logic        ovf  [QBits+1];
  side_t       sd   [QBits+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else if (en_i) begin
      vld[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den[0] <= den0;
      rem[0] <= ovf0 ? '0 : 29'(num0[62:QBits]);
      quo[0] <= '0;
      nlo[0] <= num0[QBits-1:0];
      ovf[0] <= ovf0;
      sd[0]  <= side_i;
    end
  end

  for (genvar j = 0; j < QBits; j++) begin : g_step
    localparam int Bit = QBits - 1 - j;
    logic [29:0] remsh;
    logic        ge;

    assign remsh = {rem[j], nlo[j][Bit]};
    assign ge    = remsh >= 30'(den[j]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[j+1] <= 1'b0;
      end else if (en_i) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[j+1] <= ge ? 29'(remsh - 30'(den[j])) : 29'(remsh);
        quo[j+1] <= {quo[j][39:0], ge};
        den[j+1] <= den[j];
        nlo[j+1] <= nlo[j];
        ovf[j+1] <= ovf[j];
        sd[j+1]  <= sd[j];
      end
    end
  end

  assign valid_o = vld[QBits];
  assign side_o  = sd[QBits];
  assign ovf_o   = ovf[QBits];
  assign quot_o  = quo[QBits];

endmodule

[sv/adamw_optimizer_update.sv]
// Top level of the AdamW update: configuration registers, pipeline chain and output stage.
// Depends on adamw_pkg, adamw_moments, adamw_sqrt and adamw_div.
//
//   Channel  Handshake                Payload
//   cfg      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//   in       in_valid_i/in_ready_o    param_i, grad_i, moment_in_i, variance_in_i, last_in_i
//   out      out_valid_o/out_ready_i  new_param_o, moment_out_o, variance_out_o, last_out_o
//
// One beat enters per cycle while the output is not held; the path runs through the five moment
// stages, the 28 square-root stages and the 41 quotient stages, plus divider setup and output.
// Reset clears all valid bits and loads the register defaults; no clearing pass is needed.
// A held output stalls every stage together, so nothing is dropped or repeated.
module adamw_optimizer_update import adamw_pkg::*; #(
  parameter int DATA_WIDTH = DefaultDataWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] param_i,
  input  logic [31:0] grad_i,
  input  logic [31:0] moment_in_i,
  input  logic [30:0] variance_in_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] new_param_o,
  output logic [31:0] moment_out_o,
  output logic [30:0] variance_out_o,
  output logic        last_out_o
);

  localparam int WordW = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
  localparam logic signed [63:0] SatHi = (64'sd1 <<< (WordW - 1)) - 64'sd1;
  localparam logic signed [63:0] SatLo = -SatHi - 64'sd1;

  logic [24:0] beta_one_q, beta_two_q, epsilon_q, decay_step_q;
  logic [30:0] step_rate_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_one_q   <= BetaOneRst;
      beta_two_q   <= BetaTwoRst;
      step_rate_q  <= StepRateRst;
      epsilon_q    <= EpsilonRst;
      decay_step_q <= DecayStepRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BETA_ONE:   beta_one_q   <= cfg_data_i[24:0];
        CFG_BETA_TWO:   beta_two_q   <= cfg_data_i[24:0];
        CFG_STEP_RATE:  step_rate_q  <= cfg_data_i[30:0];
        CFG_EPSILON:    epsilon_q    <= cfg_data_i[24:0];
        CFG_DECAY_STEP: decay_step_q <= cfg_data_i[24:0];
        default: ;
      endcase
    end
  end

  coef_t coef;
  assign coef.b1   = clamp_one(beta_one_q);
  assign coef.b2   = clamp_one(beta_two_q);
  assign coef.wd   = clamp_one(decay_step_q);
  assign coef.eps  = (epsilon_q == '0) ? 25'd1 : clamp_one(epsilon_q);
  assign coef.rate = step_rate_q;

  logic en;
  assign en         = out_ready_i | ~out_valid_o;
  assign in_ready_o = en;

  logic        mom_valid, sq_valid, dv_valid, dv_ovf;
  side_t       mom_side, sq_side, dv_side;
  logic [27:0] sq_root;
  logic [40:0] dv_quot;

  adamw_moments #(.DATA_WIDTH(DATA_WIDTH)) u_moments (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .param_i, .grad_i, .moment_in_i, .variance_in_i, .last_in_i,
    .coef_i(coef), .valid_o(mom_valid), .side_o(mom_side)
  );

  adamw_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(mom_valid), .side_i(mom_side),
    .valid_o(sq_valid), .side_o(sq_side), .root_o(sq_root)
  );

  adamw_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_valid), .side_i(sq_side),
    .root_i(sq_root), .eps_i(coef.eps),
    .valid_o(dv_valid), .side_o(dv_side), .ovf_o(dv_ovf), .quot_o(dv_quot)
  );

  logic [40:0]        upd_mag;
  logic signed [41:0] upd_s;
  logic signed [63:0] pn;
  logic signed [31:0] pn_sat;

  assign upd_mag = (dv_ovf || dv_quot > UpdLimit) ? UpdLimit : dv_quot;
  assign upd_s   = dv_side.m_new[31] ? -$signed({1'b0, upd_mag}) : $signed({1'b0, upd_mag});
  assign pn      = 64'(dv_side.p) - 64'(dv_side.dec) - 64'(upd_s);
  assign pn_sat  = (pn > SatHi) ? 32'(SatHi) : ((pn < SatLo) ? 32'(SatLo) : 32'(pn));

  logic        out_valid_q;
  logic [31:0] new_param_q, moment_out_q;
  logic [30:0] variance_out_q;
  logic        last_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      new_param_q    <= pn_sat;
      moment_out_q   <= dv_side.m_new;
      variance_out_q <= dv_side.v_new;
      last_out_q     <= dv_side.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign new_param_o    = new_param_q;
  assign moment_out_o   = moment_out_q;
  assign variance_out_o = variance_out_q;
  assign last_out_o     = last_out_q;

endmodule
